[design/bf3_pkg.sv]
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared types, field widths and the divide-by-nine helper for the 3x3 box
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bf3_pkg;

	localparam int PIX_W  = 8;
	localparam int ROW_W  = 12;
	localparam int COL_W  = 10;
	localparam int CFG_W  = 11;
	localparam int CSUM_W = 10;   // sum of three pixels
	localparam int SUM_W  = 12;   // sum of nine pixels
	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 32;

	localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;
	localparam logic [CFG_W-1:0] WIDTH_MIN   = 11'd3;
	localparam logic [ROW_W-1:0] ROW_MAX     = 12'd4095;

	// ceil(2^16 / 9); exact floor(sum/9) for every sum up to 9*255
	localparam int RECIP_W = 13;
	localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;

	// one new window column: row-2, row-1 and the current row
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] cur;
	} col_t;

	function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] sum);
		logic [SUM_W+RECIP_W-1:0] prod;
		prod = {{RECIP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RECIP9};
		return prod[16 +: PIX_W];
	endfunction

endpackage

`default_nettype wire

[design/bf3_win.sv]
// ----------------------------------------------------------------------------
// bf3_win
// 3x3 window kept as column sums; registers the nine-pixel sum on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module bf3_win (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        shift,
	input  wire bf3_pkg::col_t         col,
	output logic [bf3_pkg::SUM_W-1:0]  sum
);

	logic [bf3_pkg::CSUM_W-1:0] prev2_q;
	logic [bf3_pkg::CSUM_W-1:0] prev1_q;
	logic [bf3_pkg::CSUM_W-1:0] col_sum;

	assign col_sum = bf3_pkg::CSUM_W'(col.top) + bf3_pkg::CSUM_W'(col.mid)
		+ bf3_pkg::CSUM_W'(col.cur);

	// the oldest column drops out; only the two newer sums are kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev2_q <= '0;
			prev1_q <= '0;
		end else if (shift) begin
			prev2_q <= prev1_q;
			prev1_q <= col_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			sum <= bf3_pkg::SUM_W'(prev2_q) + bf3_pkg::SUM_W'(prev1_q)
				+ bf3_pkg::SUM_W'(col_sum);
		end
	end

endmodule

`default_nettype wire

[design/box_filter_3x3.sv]
// ----------------------------------------------------------------------------
// box_filter_3x3
// Streaming 3x3 mean filter over 8-bit raster pixels.
// ----------------------------------------------------------------------------
// One pixel word per clock in raster order, tuser marking the first pixel of
// a frame. For each pixel at row >= 2 and column >= 2 one result word comes out
// registered: floor(sum/9) of the 3x3 window centred one row and one column
// back, with that centre's row and column. Border pixels give no result.
// Sustained rate is one pixel per clock while m_tready is high, limited by
// the single read and single write per cycle of the line store, a 16-bit wide
// RAM of min(MAX_WIDTH, 1024) words holding the two previous rows. The line
// store has no reset and needs no clearing pass. image_width is clamped to
// 3..min(MAX_WIDTH, 1024) and should only change between frames.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_3x3 #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_wen,
	input  wire  [bf3_pkg::CFG_W-1:0]            cfg_wdata,   // image_width
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [bf3_pkg::TDATA_IN_W-1:0]       s_tdata,     // [7:0] pixel
	input  wire                                  s_tuser,     // first_of_frame
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// [7:0] mean_value, [19:8] center_row, [29:20] center_col, [31:30] zero
	output logic [bf3_pkg::TDATA_OUT_W-1:0]      m_tdata
);

	localparam int DEPTH = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [bf3_pkg::CFG_W-1:0] WMAX = bf3_pkg::CFG_W'(DEPTH);

	localparam int PW = bf3_pkg::PIX_W;
	localparam int RW = bf3_pkg::ROW_W;
	localparam int CW = bf3_pkg::COL_W;
	localparam int WW = bf3_pkg::CFG_W;

	// config and position counters
	logic [WW-1:0] width_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic          accept;
	logic [WW-1:0] w_use;
	logic [CW-1:0] col_eff;
	logic [RW-1:0] row_eff;
	logic [WW-1:0] col_inc;
	logic [WW-1:0] col_clamp;
	logic [AW-1:0] rd_addr;
	logic          emit;

	// pipeline
	logic          valid_s1;
	logic [PW-1:0] px_s1;
	logic [AW-1:0] addr_s1;
	logic          emit_s1;
	logic [RW-1:0] crow_s1;
	logic [CW-1:0] ccol_s1;
	logic [2*PW-1:0] rd_s1;     // {row-2, row-1}

	logic          valid_s2;
	logic [RW-1:0] crow_s2;
	logic [CW-1:0] ccol_s2;
	logic [bf3_pkg::SUM_W-1:0] sum_s2;

	logic          out_rdy;
	logic          s2_rdy;
	logic          adv1;
	logic          adv2;

	bf3_pkg::col_t new_col;

	logic [2*PW-1:0] lb_mem [DEPTH];

	assign out_rdy  = !m_tvalid || m_tready;
	assign s2_rdy   = !valid_s2 || out_rdy;
	assign s_tready = !valid_s1 || s2_rdy;
	assign accept   = s_tvalid && s_tready;
	assign adv1     = valid_s1 && s2_rdy;
	assign adv2     = valid_s2 && out_rdy;

	always_comb begin
		priority if (width_q < bf3_pkg::WIDTH_MIN) begin
			w_use = bf3_pkg::WIDTH_MIN;
		end else if (width_q > WMAX) begin
			w_use = WMAX;
		end else begin
			w_use = width_q;
		end
	end

	assign col_eff = s_tuser ? '0 : col_q;
	assign row_eff = s_tuser ? '0 : row_q;
	assign col_inc = {1'b0, col_eff} + WW'(1);
	// a width shrunk mid-row keeps the address inside the row
	assign col_clamp = ({1'b0, col_eff} >= w_use) ? (w_use - WW'(1)) : {1'b0, col_eff};
	assign rd_addr = col_clamp[AW-1:0];
	assign emit    = (row_eff >= RW'(2)) && (col_eff >= CW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bf3_pkg::WIDTH_RESET;
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_wen) begin
				width_q <= cfg_wdata;
			end
			if (accept) begin
				if (col_inc >= w_use) begin
					col_q <= '0;
					row_q <= (row_eff < bf3_pkg::ROW_MAX) ? row_eff + RW'(1) : row_eff;
				end else begin
					col_q <= col_inc[CW-1:0];
					row_q <= row_eff;
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			// words that produce no result end here
			if (adv1) begin
				valid_s2 <= emit_s1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
			if (adv2) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// line store: read on accept, write back the shifted pair when s1 moves on
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= lb_mem[rd_addr];
		end
		if (adv1) begin
			lb_mem[addr_s1] <= {rd_s1[PW-1:0], px_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= s_tdata[PW-1:0];
			addr_s1 <= rd_addr;
			emit_s1 <= emit;
			crow_s1 <= row_eff - RW'(1);
			ccol_s1 <= col_eff - CW'(1);
		end
		if (adv1) begin
			crow_s2 <= crow_s1;
			ccol_s2 <= ccol_s1;
		end
		if (adv2) begin
			m_tdata <= {2'b00, ccol_s2, crow_s2, bf3_pkg::div9(sum_s2)};
		end
	end

	assign new_col.top = rd_s1[2*PW-1:PW];
	assign new_col.mid = rd_s1[PW-1:0];
	assign new_col.cur = px_s1;

	bf3_win u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (adv1),
		.col    (new_col),
		.sum    (sum_s2)
	);

endmodule

`default_nettype wire

[tb/bf3_mean_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_mean_checker
// Watches the pixel, result and width-register ports of box_filter_3x3. It
// keeps its own line stores, 3x3 window and row/column counters and queues
// the window mean and centre position that each accepted pixel produces.
// Every result word is checked field by field against the oldest queued
// word. It reports a running failure count and the number of words still owed.
// ----------------------------------------------------------------------------

module bf3_mean_checker (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_wen,
	input  wire [bf3_pkg::CFG_W-1:0]       cfg_wdata,   // image_width
	input  wire                            s_tvalid,
	input  wire                            s_tready,
	input  wire [bf3_pkg::TDATA_IN_W-1:0]  s_tdata,     // [7:0] pixel
	input  wire                            s_tuser,     // first_of_frame
	input  wire                            m_tvalid,
	input  wire                            m_tready,
	// [7:0] mean_value, [19:8] center_row, [29:20] center_col, [31:30] zero
	input  wire [bf3_pkg::TDATA_OUT_W-1:0] m_tdata,
	output int                             errors,
	output int                             awaiting
);

	localparam int LINE_DEPTH = 1024;   // widest row the column counter reaches
	localparam int ROW_TOP    = 4095;

	typedef struct packed {
		logic [bf3_pkg::PIX_W-1:0] mean_value;
		logic [bf3_pkg::ROW_W-1:0] center_row;
		logic [bf3_pkg::COL_W-1:0] center_col;
	} window_mean_t;

	logic [bf3_pkg::CFG_W-1:0] width_reg;
	logic [bf3_pkg::PIX_W-1:0] prev_row [LINE_DEPTH];
	logic [bf3_pkg::PIX_W-1:0] prev2_row [LINE_DEPTH];
	logic [bf3_pkg::PIX_W-1:0] win [3][3];   // [row][col], index 2 is newest
	int unsigned      col_cnt;
	int unsigned      row_cnt;
	window_mean_t     expected_means [$];
	int               fail_n;

	task automatic filter_pixel(input logic [bf3_pkg::PIX_W-1:0] px, input logic sof);
		int unsigned w;
		int unsigned c;
		int unsigned sum;
		window_mean_t res;
		w = 32'(width_reg);
		if (w < 3) w = 3;
		if (w > LINE_DEPTH) w = LINE_DEPTH;
		if (sof) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		// column already past a shrunk width: stay on the last store entry
		c = (col_cnt >= w) ? w - 1 : col_cnt;
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = prev2_row[c];
		win[1][2] = prev_row[c];
		win[2][2] = px;
		prev2_row[c] = prev_row[c];
		prev_row[c] = px;
		if (row_cnt >= 2 && col_cnt >= 2) begin
			sum = 0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					sum += 32'(win[i][j]);
			res.mean_value = bf3_pkg::PIX_W'(sum / 9);
			res.center_row = bf3_pkg::ROW_W'(row_cnt - 1);
			res.center_col = bf3_pkg::COL_W'(col_cnt - 1);
			expected_means.push_back(res);
		end
		if (col_cnt + 1 >= w) begin
			col_cnt = 0;
			if (row_cnt < ROW_TOP) row_cnt++;
		end else begin
			col_cnt = col_cnt + 1;
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			fail_n++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		window_mean_t want;
		if (!arst_n) begin
			width_reg = bf3_pkg::WIDTH_RESET;
			for (int i = 0; i < LINE_DEPTH; i++) begin
				prev_row[i] = '0;
				prev2_row[i] = '0;
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					win[i][j] = '0;
			col_cnt = 0;
			row_cnt = 0;
			expected_means.delete();
			fail_n = 0;
			errors <= 0;
			awaiting <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_means.size() == 0) begin
					$display("%0t: result word expected none, got %h", $time, m_tdata);
					fail_n++;
				end else begin
					want = expected_means.pop_front();
					check_field("mean_value", 32'(want.mean_value), 32'(m_tdata[7:0]));
					check_field("center_row", 32'(want.center_row), 32'(m_tdata[19:8]));
					check_field("center_col", 32'(want.center_col), 32'(m_tdata[29:20]));
					check_field("padding", 0, 32'(m_tdata[31:30]));
				end
			end
			if (s_tvalid && s_tready)
				filter_pixel(s_tdata[7:0], s_tuser);
			if (cfg_wen)
				width_reg = cfg_wdata;
			errors <= fail_n;
			awaiting <= expected_means.size();
		end
	end

endmodule

[tb/tb_box_filter_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_filter_3x3
// Stimulus and verdict for the 3x3 box filter.
// ----------------------------------------------------------------------------
// Runs a partial row at the reset width, a short directed set (all-white and
// all-black windows, frame restarts), a partial widest row shrunk in the
// middle, a register value above range, then random frames and continued
// streams with random widths, content and frame-start noise. Both sides
// stall in random bursts; the last frame streams without gaps.
// ----------------------------------------------------------------------------

module tb_box_filter_3x3;

	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int RANDOM_PIXELS  = 250;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RESET_W_PIXELS = 40;
	localparam int WIDE_PIXELS    = 100;

	typedef enum int {FILL_RANDOM, FILL_WHITE, FILL_BLACK, FILL_MIXED} fill_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_wen   = 1'b0;
	logic [bf3_pkg::CFG_W-1:0]       cfg_wdata = '0;
	logic                            s_tvalid  = 1'b0;
	logic [bf3_pkg::TDATA_IN_W-1:0]  s_tdata   = '0;
	logic                            s_tuser   = 1'b0;
	logic                            m_tready  = 1'b0;
	wire                             s_tready;
	wire                             m_tvalid;
	wire [bf3_pkg::TDATA_OUT_W-1:0]  m_tdata;

	int          errors;
	int          awaiting;
	bit          gaps_on = 1'b1;
	int          cycles = 0;
	int unsigned line_w = 32'(bf3_pkg::WIDTH_RESET);   // row length the block applies
	int          random_sent = 0;

	box_filter_3x3 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	bf3_mean_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.errors    (errors),
		.awaiting  (awaiting)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side: random stall bursts while gaps are enabled
	initial begin : rx_stall
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 6) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic int unsigned applied_width(input int unsigned v);
		if (v < 3) return 3;
		if (v > 1024) return 1024;
		return v;
	endfunction

	function automatic logic [7:0] pick_pixel(input fill_t f);
		unique case (f)
			FILL_WHITE: return 8'hFF;
			FILL_BLACK: return 8'h00;
			FILL_MIXED: begin
				unique case ($urandom_range(0, 2))
					0: return 8'h00;
					1: return 8'hFF;
					default: return 8'($urandom_range(0, 255));
				endcase
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// all calls start and end on a rising edge
	task automatic send_pixel(input logic [7:0] px, input logic sof);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		s_tuser  <= sof;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_pixels(input int n, input bit sof_first, input fill_t f,
			input bit noisy);
		bit sof;
		for (int i = 0; i < n; i++) begin
			sof = (i == 0 && sof_first) || (noisy && $urandom_range(0, 39) == 0);
			send_pixel(pick_pixel(f), sof);
		end
	endtask

	// hold the stream until every owed word is out and the pipeline is empty
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input logic [bf3_pkg::CFG_W-1:0] v);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		line_w = applied_width(32'(v));
	endtask

	function automatic fill_t random_fill();
		unique case ($urandom_range(0, 7))
			0: return FILL_WHITE;
			1: return FILL_BLACK;
			2: return FILL_MIXED;
			default: return FILL_RANDOM;
		endcase
	endfunction

	initial begin : stimulus
		int n;
		int r;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset width, first part of the top row: no words come out
		send_pixels(RESET_W_PIXELS, 1'b1, FILL_RANDOM, 1'b0);
		drain();

		// narrowest row (register below range), flat windows and restarts
		write_width(11'd0);
		send_pixels(9, 1'b1, FILL_WHITE, 1'b0);
		send_pixels(3, 1'b0, FILL_BLACK, 1'b0);
		send_pixels(9, 1'b1, FILL_BLACK, 1'b0);
		send_pixels(3, 1'b0, FILL_WHITE, 1'b0);
		send_pixel(8'h5A, 1'b0);
		send_pixel(8'hA5, 1'b1);
		drain();

		// widest row, then shrink in the middle of it
		write_width(11'd1024);
		send_pixels(WIDE_PIXELS, 1'b1, FILL_RANDOM, 1'b0);
		drain();
		write_width(11'd5);
		send_pixels(20, 1'b0, FILL_RANDOM, 1'b0);
		drain();

		// register above range clamps to the widest row
		write_width(11'h7FF);
		send_pixels(RESET_W_PIXELS, 1'b1, FILL_MIXED, 1'b0);
		drain();

		while (random_sent < RANDOM_PIXELS) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 2) != 0) begin
				// new frame at a new width
				drain();
				r = $urandom_range(0, 9);
				if (r == 0)
					write_width(bf3_pkg::CFG_W'($urandom_range(0, 2)));
				else if (r == 1)
					write_width(bf3_pkg::CFG_W'($urandom_range(9, 40)));
				else
					write_width(bf3_pkg::CFG_W'($urandom_range(3, 8)));
				n = (line_w > 8 ? 3 : $urandom_range(3, 6)) * line_w;
				send_pixels(n, 1'b1, random_fill(), 1'b1);
			end else begin
				// keep streaming the current frame, maybe on a narrower row
				if ($urandom_range(0, 1) != 0) begin
					drain();
					write_width(bf3_pkg::CFG_W'($urandom_range(0, line_w)));
				end
				n = $urandom_range(1, 3 * line_w);
				send_pixels(n, 1'b0, random_fill(), 1'b1);
			end
			random_sent += n;
		end

		// closing frame streams with no stalls on either side
		drain();
		gaps_on = 1'b0;
		write_width(bf3_pkg::CFG_W'($urandom_range(3, 8)));
		send_pixels(8 * line_w, 1'b1, FILL_RANDOM, 1'b0);
		drain();

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
